// ----- src/packet_header_blocklist_filter_macros.svh -----
// assertion macros of the blocklist filter checker
`ifndef PACKET_HEADER_BLOCKLIST_FILTER_MACROS_SVH
`define PACKET_HEADER_BLOCKLIST_FILTER_MACROS_SVH

// antecedent implies consequent in the same cycle, reset masks the check
`define PBF_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define PBF_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pbf_pkg.sv -----
// types, codes and helper functions of the packet header blocklist filter
package pbf_pkg;

	// command codes
	localparam logic [2:0] CMD_CLASSIFY  = 3'd0;
	localparam logic [2:0] CMD_SRC_IP    = 3'd1;
	localparam logic [2:0] CMD_DST_IP    = 3'd2;
	localparam logic [2:0] CMD_SRC_PORT  = 3'd3;
	localparam logic [2:0] CMD_DST_PORT  = 3'd4;

	// reason codes
	localparam logic [2:0] RSN_HTTP      = 3'd0;
	localparam logic [2:0] RSN_ICMP      = 3'd1;
	localparam logic [2:0] RSN_DNS       = 3'd2;
	localparam logic [2:0] RSN_SRC_IP    = 3'd3;
	localparam logic [2:0] RSN_DST_IP    = 3'd4;
	localparam logic [2:0] RSN_SRC_PORT  = 3'd5;
	localparam logic [2:0] RSN_DST_PORT  = 3'd6;
	localparam logic [2:0] RSN_DEFAULT   = 3'd7;

	// deciding layer codes
	localparam logic [1:0] LYR_L3        = 2'd0;
	localparam logic [1:0] LYR_L4        = 2'd1;
	localparam logic [1:0] LYR_L7        = 2'd2;

	// verdict codes
	localparam logic VRD_ACCEPT          = 1'b0;
	localparam logic VRD_DROP            = 1'b1;

	// well known ports and protocol
	localparam logic [15:0] PORT_HTTP     = 16'd80;
	localparam logic [15:0] PORT_HTTPS    = 16'd443;
	localparam logic [15:0] PORT_HTTP_ALT = 16'd8080;
	localparam logic [15:0] PORT_EPHEM    = 16'd1024;
	localparam logic [15:0] PORT_DNS      = 16'd53;
	localparam logic [7:0]  PROTO_ICMP    = 8'd1;

	// one request beat
	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  protocol;
		logic [3:0]  entry_index;
		logic        entry_valid;
		logic [31:0] entry_addr;
		logic [5:0]  entry_prefix;
		logic [15:0] entry_port;
	} pbf_req_t;

	// one result beat
	typedef struct packed {
		logic       verdict;
		logic [2:0] reason;
		logic [1:0] layer;
	} pbf_rsp_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FINISH,
		ST_RESULT
	} pbf_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic write;
		logic scan;
	} pbf_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic is_load;
		logic is_classify;
		logic early;
		logic scan_last;
	} pbf_sts_t;

	// prefix length to network mask, anything above 32 is an exact address
	function automatic logic [31:0] prefix_to_mask(input logic [5:0] pfx);
		logic [5:0] p;
		begin
			p = (pfx > 6'd32) ? 6'd32 : pfx;
			if (p == 6'd0) begin
				prefix_to_mask = 32'h0;
			end else begin
				prefix_to_mask = 32'hFFFF_FFFF << (6'd32 - p);
			end
		end
	endfunction

endpackage

// ----- src/packet_header_blocklist_filter.sv -----
// top level of the packet header blocklist filter
//
// Command channel: a request beat (req) is taken at a rising edge where start is
// high and busy is low. cmd selects a classify or a write into one of the four
// tables (source net, destination net, source port, destination port).
// Result channel: done is high for exactly one cycle and carries rsp (verdict,
// reason, layer). Only classify commands give a result; load and unused
// commands give none.
// A classify hitting an early accept (http response, icmp, dns) goes from the
// decode state straight to the result state. Any other classify scans the
// tables one entry per table per cycle in the scan state, then passes the finish
// state; the scan covers N entries, N being the larger of IP_TABLE_ENTRIES and
// PORT_TABLE_ENTRIES (16 at the defaults), through the single read port of each
// table ram. A load writes its table in the decode state before the next beat is
// taken. busy is low in the done cycle, so a new beat may be taken there.
// Reset clears all valid bits at once, so every table reads empty; there is no
// clearing pass. The receiver cannot stall: each result beat must be taken.
module packet_header_blocklist_filter import pbf_pkg::*; #(
	parameter int IP_TABLE_ENTRIES   = 16,
	parameter int PORT_TABLE_ENTRIES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pbf_req_t req,
	output logic     done,
	output pbf_rsp_t rsp
);

	pbf_ctl_t ctl;
	pbf_sts_t sts;

	// sequencing
	pbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// tables and match logic
	pbf_dp #(
		.IP_TABLE_ENTRIES   (IP_TABLE_ENTRIES),
		.PORT_TABLE_ENTRIES (PORT_TABLE_ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// ----- src/pbf_ram.sv -----
// generic simple dual port ram with registered read
module pbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/pbf_ctrl.sv -----
// controller state machine of the blocklist filter
module pbf_ctrl import pbf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  pbf_sts_t sts,
	output logic     busy,
	output logic     done,
	output pbf_ctl_t ctl
);

	pbf_state_t state_q;
	pbf_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.is_classify && sts.early) begin
					state_d = ST_RESULT;
				end else if (sts.is_classify) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				state_d = start ? ST_DECODE : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy        = 1'b1;
		done        = 1'b0;
		ctl.capture = 1'b0;
		ctl.write   = 1'b0;
		ctl.scan    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			ST_DECODE: begin
				ctl.write = sts.is_load;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
			end
			ST_FINISH: begin
				busy = 1'b1;
			end
			ST_RESULT: begin
				busy        = 1'b0;
				done        = 1'b1;
				ctl.capture = start;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ----- src/pbf_dp.sv -----
// datapath: request register, tables, scan counter and match logic
module pbf_dp import pbf_pkg::*; #(
	parameter int IP_TABLE_ENTRIES   = 16,
	parameter int PORT_TABLE_ENTRIES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  pbf_req_t req,
	input  pbf_ctl_t ctl,
	output pbf_sts_t sts,
	output pbf_rsp_t rsp
);

	localparam int IP_AW   = (IP_TABLE_ENTRIES > 1) ? $clog2(IP_TABLE_ENTRIES) : 1;
	localparam int PORT_AW = (PORT_TABLE_ENTRIES > 1) ? $clog2(PORT_TABLE_ENTRIES) : 1;
	localparam int MAXN    = (IP_TABLE_ENTRIES > PORT_TABLE_ENTRIES) ?
		IP_TABLE_ENTRIES : PORT_TABLE_ENTRIES;
	localparam int SW      = (MAXN > 1) ? $clog2(MAXN) : 1;

	localparam logic [SW-1:0] SCAN_LAST   = SW'(MAXN - 1);
	localparam logic [SW:0]   IP_SCAN_LIM = (SW + 1)'(IP_TABLE_ENTRIES);
	localparam logic [SW:0]   PT_SCAN_LIM = (SW + 1)'(PORT_TABLE_ENTRIES);
	localparam logic [8:0]    IP_IDX_LIM  = 9'(IP_TABLE_ENTRIES);
	localparam logic [8:0]    PT_IDX_LIM  = 9'(PORT_TABLE_ENTRIES);

	pbf_req_t req_q;
	logic [SW-1:0] scan_q;

	logic [IP_TABLE_ENTRIES-1:0]   src_net_vld_q;
	logic [IP_TABLE_ENTRIES-1:0]   dst_net_vld_q;
	logic [PORT_TABLE_ENTRIES-1:0] sport_vld_q;
	logic [PORT_TABLE_ENTRIES-1:0] dport_vld_q;

	logic src_ip_hit_q, dst_ip_hit_q, sport_hit_q, dport_hit_q;
	logic src_ip_ok_s1, dst_ip_ok_s1, sport_ok_s1, dport_ok_s1;

	logic [IP_AW-1:0]   ip_waddr, ip_raddr;
	logic [PORT_AW-1:0] pt_waddr, pt_raddr;
	logic               ip_idx_ok, pt_idx_ok, ip_scan_ok, pt_scan_ok;
	logic [31:0]        wmask;
	logic [63:0]        net_wdata;
	logic               we_src_net, we_dst_net, we_sport, we_dport;
	logic [63:0]        src_net_rd, dst_net_rd;
	logic [15:0]        sport_rd, dport_rd;
	logic               is_http, is_icmp, is_dns;

	// request register
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= req;
		end
	end

	// load decode
	always_comb begin
		ip_idx_ok  = {5'd0, req_q.entry_index} < IP_IDX_LIM;
		pt_idx_ok  = {5'd0, req_q.entry_index} < PT_IDX_LIM;
		ip_waddr   = IP_AW'(req_q.entry_index);
		pt_waddr   = PORT_AW'(req_q.entry_index);
		wmask      = prefix_to_mask(req_q.entry_prefix);
		net_wdata  = {req_q.entry_addr & wmask, wmask};
		we_src_net = ctl.write && (req_q.cmd == CMD_SRC_IP) && ip_idx_ok;
		we_dst_net = ctl.write && (req_q.cmd == CMD_DST_IP) && ip_idx_ok;
		we_sport   = ctl.write && (req_q.cmd == CMD_SRC_PORT) && pt_idx_ok;
		we_dport   = ctl.write && (req_q.cmd == CMD_DST_PORT) && pt_idx_ok;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_net_vld_q <= '0;
			dst_net_vld_q <= '0;
			sport_vld_q   <= '0;
			dport_vld_q   <= '0;
		end else begin
			if (we_src_net) src_net_vld_q[ip_waddr] <= req_q.entry_valid;
			if (we_dst_net) dst_net_vld_q[ip_waddr] <= req_q.entry_valid;
			if (we_sport)   sport_vld_q[pt_waddr]   <= req_q.entry_valid;
			if (we_dport)   dport_vld_q[pt_waddr]   <= req_q.entry_valid;
		end
	end

	// table storage: network rows hold {addr, mask}
	pbf_ram #(.WIDTH(64), .DEPTH(IP_TABLE_ENTRIES)) u_src_net (
		.clk(clk), .we(we_src_net), .waddr(ip_waddr), .wdata(net_wdata),
		.raddr(ip_raddr), .rdata(src_net_rd)
	);
	pbf_ram #(.WIDTH(64), .DEPTH(IP_TABLE_ENTRIES)) u_dst_net (
		.clk(clk), .we(we_dst_net), .waddr(ip_waddr), .wdata(net_wdata),
		.raddr(ip_raddr), .rdata(dst_net_rd)
	);
	pbf_ram #(.WIDTH(16), .DEPTH(PORT_TABLE_ENTRIES)) u_sport (
		.clk(clk), .we(we_sport), .waddr(pt_waddr), .wdata(req_q.entry_port),
		.raddr(pt_raddr), .rdata(sport_rd)
	);
	pbf_ram #(.WIDTH(16), .DEPTH(PORT_TABLE_ENTRIES)) u_dport (
		.clk(clk), .we(we_dport), .waddr(pt_waddr), .wdata(req_q.entry_port),
		.raddr(pt_raddr), .rdata(dport_rd)
	);

	// scan address and range
	always_comb begin
		ip_raddr   = IP_AW'(scan_q);
		pt_raddr   = PORT_AW'(scan_q);
		ip_scan_ok = {1'b0, scan_q} < IP_SCAN_LIM;
		pt_scan_ok = {1'b0, scan_q} < PT_SCAN_LIM;
	end

	// scan counter and read stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			src_ip_ok_s1 <= 1'b0;
			dst_ip_ok_s1 <= 1'b0;
			sport_ok_s1  <= 1'b0;
			dport_ok_s1  <= 1'b0;
		end else begin
			if (ctl.capture) begin
				scan_q <= '0;
			end else if (ctl.scan) begin
				scan_q <= scan_q + 1'b1;
			end
			src_ip_ok_s1 <= ctl.scan && ip_scan_ok && src_net_vld_q[ip_raddr];
			dst_ip_ok_s1 <= ctl.scan && ip_scan_ok && dst_net_vld_q[ip_raddr];
			sport_ok_s1  <= ctl.scan && pt_scan_ok && sport_vld_q[pt_raddr];
			dport_ok_s1  <= ctl.scan && pt_scan_ok && dport_vld_q[pt_raddr];
		end
	end

	// hit accumulation, one entry per table per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ip_hit_q <= 1'b0;
			dst_ip_hit_q <= 1'b0;
			sport_hit_q  <= 1'b0;
			dport_hit_q  <= 1'b0;
		end else if (ctl.capture) begin
			src_ip_hit_q <= 1'b0;
			dst_ip_hit_q <= 1'b0;
			sport_hit_q  <= 1'b0;
			dport_hit_q  <= 1'b0;
		end else begin
			if (src_ip_ok_s1 && ((req_q.src_ip & src_net_rd[31:0]) == src_net_rd[63:32]))
				src_ip_hit_q <= 1'b1;
			if (dst_ip_ok_s1 && ((req_q.dst_ip & dst_net_rd[31:0]) == dst_net_rd[63:32]))
				dst_ip_hit_q <= 1'b1;
			if (sport_ok_s1 && (req_q.sport == sport_rd))
				sport_hit_q <= 1'b1;
			if (dport_ok_s1 && (req_q.dport == dport_rd))
				dport_hit_q <= 1'b1;
		end
	end

	// early accept checks
	always_comb begin
		is_http = (req_q.sport inside {PORT_HTTP, PORT_HTTPS, PORT_HTTP_ALT}) &&
			(req_q.dport > PORT_EPHEM);
		is_icmp = req_q.protocol == PROTO_ICMP;
		is_dns  = (req_q.sport == PORT_DNS) || (req_q.dport == PORT_DNS);
	end

	// status to controller
	always_comb begin
		sts.is_load     = req_q.cmd inside {CMD_SRC_IP, CMD_DST_IP, CMD_SRC_PORT,
			CMD_DST_PORT};
		sts.is_classify = req_q.cmd == CMD_CLASSIFY;
		sts.early       = is_http || is_icmp || is_dns;
		sts.scan_last   = scan_q == SCAN_LAST;
	end

	// verdict in priority order
	always_comb begin
		if (is_http) begin
			rsp = '{verdict: VRD_ACCEPT, reason: RSN_HTTP, layer: LYR_L3};
		end else if (is_icmp) begin
			rsp = '{verdict: VRD_ACCEPT, reason: RSN_ICMP, layer: LYR_L3};
		end else if (is_dns) begin
			rsp = '{verdict: VRD_ACCEPT, reason: RSN_DNS, layer: LYR_L3};
		end else if (src_ip_hit_q) begin
			rsp = '{verdict: VRD_DROP, reason: RSN_SRC_IP, layer: LYR_L3};
		end else if (dst_ip_hit_q) begin
			rsp = '{verdict: VRD_DROP, reason: RSN_DST_IP, layer: LYR_L3};
		end else if (sport_hit_q) begin
			rsp = '{verdict: VRD_DROP, reason: RSN_SRC_PORT, layer: LYR_L4};
		end else if (dport_hit_q) begin
			rsp = '{verdict: VRD_DROP, reason: RSN_DST_PORT, layer: LYR_L4};
		end else begin
			rsp = '{verdict: VRD_ACCEPT, reason: RSN_DEFAULT, layer: LYR_L7};
		end
	end

endmodule

// ----- src/pbf_chk.sv -----
// port level checker of the blocklist filter and its bind
`include "packet_header_blocklist_filter_macros.svh"

module pbf_chk import pbf_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input pbf_req_t req,
	input logic     done,
	input pbf_rsp_t rsp
);

	logic accept;
	logic icmp_req;
	logic drop_beat;
	logic table_reason;

	// accepted beat and an accepted icmp classify
	always_comb begin
		accept   = start && !busy;
		icmp_req = accept && (req.cmd == CMD_CLASSIFY) && (req.protocol == PROTO_ICMP);
	end

	// drop result and whether its reason names a table
	always_comb begin
		drop_beat    = done && (rsp.verdict == VRD_DROP);
		table_reason = rsp.reason inside {RSN_SRC_IP, RSN_DST_IP, RSN_SRC_PORT, RSN_DST_PORT};
	end

	// the block is busy right after taking a beat
	`PBF_NEXT(a_busy_after_accept, accept, busy, "not busy after accepted beat")

	// a result lasts one cycle only
	`PBF_NEXT(a_done_single, done, !done, "done held for more than one cycle")

	// icmp classify is accepted through the decode and result states with no table scan
	`PBF_IMPLIES(a_icmp_fast, icmp_req, ##2 (done && (rsp.verdict == VRD_ACCEPT)), "slow icmp")

	// a drop always names a table
	`PBF_IMPLIES(a_drop_reason, drop_beat, table_reason, "drop with non table reason")

endmodule

bind packet_header_blocklist_filter pbf_chk u_pbf_chk (.*);

// ----- dv/packet_header_blocklist_filter_tb.sv -----
// self-checking testbench: directed and random header and table-load beats against a local model
module packet_header_blocklist_filter_tb;
	import pbf_pkg::*;

	localparam int NET_SLOTS    = 16;
	localparam int PORT_SLOTS   = 16;
	localparam int RANDOM_BEATS = 650;
	// wait for the longest classify, taken with margin
	localparam int SCAN_SETTLE  = 25;
	localparam int LOAD_SETTLE  = 4;
	localparam int RUN_LIMIT    = 2_000_000;
	localparam int PRINT_CAP    = 50;

	// command codes that the block ignores
	localparam logic [2:0] CMD_UNUSED5 = 3'd5;
	localparam logic [2:0] CMD_UNUSED6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED7 = 3'd7;

	typedef logic [31:0] net_tbl_t [NET_SLOTS];
	typedef logic [15:0] port_tbl_t [PORT_SLOTS];

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	pbf_req_t req;
	pbf_rsp_t rsp;

	// local copy of the four blocklists
	net_tbl_t              src_net_base, src_net_keep, dst_net_base, dst_net_keep;
	logic [NET_SLOTS-1:0]  src_net_on, dst_net_on;
	port_tbl_t             sport_blk, dport_blk;
	logic [PORT_SLOTS-1:0] sport_on, dport_on;

	pbf_rsp_t    pending_verdicts [$];
	int          mismatches;
	int unsigned gap_max;

	packet_header_blocklist_filter #(
		.IP_TABLE_ENTRIES   (NET_SLOTS),
		.PORT_TABLE_ENTRIES (PORT_SLOTS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP) begin
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		end
		mismatches++;
	endtask

	// network mask of a prefix length, above 32 means exact
	function automatic logic [31:0] net_mask(input logic [5:0] pfx);
		logic [5:0] bits;
		bits = (pfx > 6'd32) ? 6'd32 : pfx;
		return ~(32'hFFFF_FFFF >> bits);
	endfunction

	function automatic logic net_hit(input logic [NET_SLOTS-1:0] on, input net_tbl_t base,
			input net_tbl_t keep, input logic [31:0] ip);
		for (int i = 0; i < NET_SLOTS; i++) begin
			if (on[i] && ((ip & keep[i]) == base[i])) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic port_hit(input logic [PORT_SLOTS-1:0] on, input port_tbl_t blk,
			input logic [15:0] port);
		for (int i = 0; i < PORT_SLOTS; i++) begin
			if (on[i] && (blk[i] == port)) return 1'b1;
		end
		return 1'b0;
	endfunction

	// update the blocklists or queue the verdict of one accepted beat
	function automatic void blocklist_apply(input pbf_req_t b);
		logic [31:0] keep;
		pbf_rsp_t    r;
		keep = net_mask(b.entry_prefix);
		case (b.cmd)
			CMD_SRC_IP: begin
				if (int'(b.entry_index) < NET_SLOTS) begin
					src_net_base[b.entry_index] = b.entry_addr & keep;
					src_net_keep[b.entry_index] = keep;
					src_net_on[b.entry_index]   = b.entry_valid;
				end
			end
			CMD_DST_IP: begin
				if (int'(b.entry_index) < NET_SLOTS) begin
					dst_net_base[b.entry_index] = b.entry_addr & keep;
					dst_net_keep[b.entry_index] = keep;
					dst_net_on[b.entry_index]   = b.entry_valid;
				end
			end
			CMD_SRC_PORT: begin
				if (int'(b.entry_index) < PORT_SLOTS) begin
					sport_blk[b.entry_index] = b.entry_port;
					sport_on[b.entry_index]  = b.entry_valid;
				end
			end
			CMD_DST_PORT: begin
				if (int'(b.entry_index) < PORT_SLOTS) begin
					dport_blk[b.entry_index] = b.entry_port;
					dport_on[b.entry_index]  = b.entry_valid;
				end
			end
			CMD_CLASSIFY: begin
				if ((b.sport == PORT_HTTP || b.sport == PORT_HTTPS ||
						b.sport == PORT_HTTP_ALT) && b.dport > PORT_EPHEM) begin
					r = '{verdict: VRD_ACCEPT, reason: RSN_HTTP, layer: LYR_L3};
				end else if (b.protocol == PROTO_ICMP) begin
					r = '{verdict: VRD_ACCEPT, reason: RSN_ICMP, layer: LYR_L3};
				end else if (b.sport == PORT_DNS || b.dport == PORT_DNS) begin
					r = '{verdict: VRD_ACCEPT, reason: RSN_DNS, layer: LYR_L3};
				end else if (net_hit(src_net_on, src_net_base, src_net_keep, b.src_ip)) begin
					r = '{verdict: VRD_DROP, reason: RSN_SRC_IP, layer: LYR_L3};
				end else if (net_hit(dst_net_on, dst_net_base, dst_net_keep, b.dst_ip)) begin
					r = '{verdict: VRD_DROP, reason: RSN_DST_IP, layer: LYR_L3};
				end else if (port_hit(sport_on, sport_blk, b.sport)) begin
					r = '{verdict: VRD_DROP, reason: RSN_SRC_PORT, layer: LYR_L4};
				end else if (port_hit(dport_on, dport_blk, b.dport)) begin
					r = '{verdict: VRD_DROP, reason: RSN_DST_PORT, layer: LYR_L4};
				end else begin
					r = '{verdict: VRD_ACCEPT, reason: RSN_DEFAULT, layer: LYR_L7};
				end
				pending_verdicts = {pending_verdicts, r};
			end
			default: begin
			end
		endcase
	endfunction

	// send one beat after a random gap, start stays high into the next beat
	task automatic send_beat(input pbf_req_t b);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		blocklist_apply(b);
	endtask

	// stop sending until every queued verdict has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0 || busy) @(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	// compare each result beat with the oldest queued verdict
	always @(posedge clk) begin : result_check
		pbf_rsp_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected result beat", 32'(rsp), 32'd0);
			end else begin
				want = pending_verdicts.pop_front();
				if (rsp.verdict !== want.verdict) begin
					report_mismatch("verdict", 32'(rsp.verdict), 32'(want.verdict));
				end
				if (rsp.reason !== want.reason) begin
					report_mismatch("reason", 32'(rsp.reason), 32'(want.reason));
				end
				if (rsp.layer !== want.layer) begin
					report_mismatch("layer", 32'(rsp.layer), 32'(want.layer));
				end
			end
		end
	end

	// beat with every field random
	function automatic pbf_req_t random_beat();
		pbf_req_t b;
		b.cmd          = 3'($urandom);
		b.src_ip       = $urandom;
		b.dst_ip       = $urandom;
		b.sport        = 16'($urandom);
		b.dport        = 16'($urandom);
		b.protocol     = 8'($urandom);
		b.entry_index  = 4'($urandom);
		b.entry_valid  = 1'($urandom);
		b.entry_addr   = $urandom;
		b.entry_prefix = 6'($urandom);
		b.entry_port   = 16'($urandom);
		return b;
	endfunction

	function automatic pbf_req_t header(input logic [31:0] sip, input logic [31:0] dip,
			input logic [15:0] sp, input logic [15:0] dp, input logic [7:0] proto);
		pbf_req_t b;
		b          = random_beat();
		b.cmd      = CMD_CLASSIFY;
		b.src_ip   = sip;
		b.dst_ip   = dip;
		b.sport    = sp;
		b.dport    = dp;
		b.protocol = proto;
		return b;
	endfunction

	function automatic pbf_req_t net_entry_beat(input logic [2:0] cmd, input logic [3:0] idx,
			input logic valid, input logic [31:0] addr, input logic [5:0] pfx);
		pbf_req_t b;
		b              = random_beat();
		b.cmd          = cmd;
		b.entry_index  = idx;
		b.entry_valid  = valid;
		b.entry_addr   = addr;
		b.entry_prefix = pfx;
		return b;
	endfunction

	function automatic pbf_req_t port_entry_beat(input logic [2:0] cmd, input logic [3:0] idx,
			input logic valid, input logic [15:0] port);
		pbf_req_t b;
		b             = random_beat();
		b.cmd         = cmd;
		b.entry_index = idx;
		b.entry_valid = valid;
		b.entry_port  = port;
		return b;
	endfunction

	// random table write, prefixes mostly long so lower checks stay reachable
	function automatic pbf_req_t load_beat();
		pbf_req_t b;
		int       pick;
		b = random_beat();
		case ($urandom_range(0, 3))
			0: b.cmd = CMD_SRC_IP;
			1: b.cmd = CMD_DST_IP;
			2: b.cmd = CMD_SRC_PORT;
			default: b.cmd = CMD_DST_PORT;
		endcase
		b.entry_valid = ($urandom_range(0, 9) < 7);
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			// a match-all entry would hide every lower check, so it lands cleared
			b.entry_prefix = 6'd0;
			b.entry_valid  = 1'b0;
		end else if (pick < 14) begin
			b.entry_prefix = 6'($urandom_range(33, 63));
		end else if (pick < 40) begin
			b.entry_prefix = 6'd32;
		end else begin
			b.entry_prefix = 6'($urandom_range(12, 31));
		end
		return b;
	endfunction

	// random header, mostly aimed at one check
	function automatic pbf_req_t header_beat();
		pbf_req_t b;
		int       kind;
		int       slot;
		b    = random_beat();
		b.cmd = CMD_CLASSIFY;
		kind = $urandom_range(0, 99);
		slot = $urandom_range(0, NET_SLOTS - 1);
		if (kind < 6) begin
			case ($urandom_range(0, 2))
				0: b.sport = PORT_HTTP;
				1: b.sport = PORT_HTTPS;
				default: b.sport = PORT_HTTP_ALT;
			endcase
			if ($urandom_range(0, 1)) b.dport = 16'($urandom_range(1000, 1050));
		end else if (kind < 10) begin
			b.protocol = PROTO_ICMP;
		end else if (kind < 14) begin
			if ($urandom_range(0, 1)) b.sport = PORT_DNS;
			else b.dport = PORT_DNS;
		end else if (kind < 34) begin
			b.src_ip = src_net_base[slot] | (b.src_ip & ~src_net_keep[slot]);
		end else if (kind < 52) begin
			b.dst_ip = dst_net_base[slot] | (b.dst_ip & ~dst_net_keep[slot]);
		end else if (kind < 70) begin
			b.sport = sport_blk[$urandom_range(0, PORT_SLOTS - 1)];
		end else if (kind < 88) begin
			b.dport = dport_blk[$urandom_range(0, PORT_SLOTS - 1)];
		end
		return b;
	endfunction

	// empty tables: extremes of the header and ignored command codes
	task automatic test_empty_tables();
		send_beat(header(32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
		send_beat(header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_beat(net_entry_beat(CMD_UNUSED5, 4'd0, 1'b1, 32'h0, 6'd0));
		send_beat(net_entry_beat(CMD_UNUSED6, 4'd15, 1'b1, 32'hFFFF_FFFF, 6'd63));
		send_beat(port_entry_beat(CMD_UNUSED7, 4'd3, 1'b1, 16'h0));
	endtask

	// fixed early accepts, their order and the ephemeral port boundary
	task automatic test_early_accepts();
		send_beat(header($urandom, $urandom, PORT_HTTP, 16'd1025, 8'd6));
		send_beat(header($urandom, $urandom, PORT_HTTPS, PORT_EPHEM, 8'd6));
		send_beat(header($urandom, $urandom, PORT_HTTP_ALT, 16'hFFFF, PROTO_ICMP));
		send_beat(header($urandom, $urandom, PORT_DNS, 16'd2000, PROTO_ICMP));
		send_beat(header($urandom, $urandom, PORT_DNS, 16'd2000, 8'd17));
		send_beat(header($urandom, $urandom, 16'd3000, PORT_DNS, 8'd17));
	endtask

	// each table, its priority, exact and match-all prefixes, clearing a slot
	task automatic test_table_loads();
		send_beat(net_entry_beat(CMD_SRC_IP, 4'd0, 1'b1, 32'hC0A8_0155, 6'd24));
		send_beat(net_entry_beat(CMD_DST_IP, 4'd15, 1'b1, 32'hFFFF_FFFF, 6'd63));
		send_beat(port_entry_beat(CMD_SRC_PORT, 4'd3, 1'b1, 16'h0));
		send_beat(port_entry_beat(CMD_DST_PORT, 4'd15, 1'b1, 16'hFFFF));
		send_beat(header(32'hC0A8_01F0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 8'd6));
		send_beat(header(32'hC0A8_02F0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 8'd6));
		send_beat(header(32'h0A00_0001, 32'hFFFF_FFFE, 16'h0, 16'hFFFF, 8'd6));
		send_beat(header(32'h0A00_0001, 32'hFFFF_FFFE, 16'd7, 16'hFFFF, 8'd6));
		send_beat(net_entry_beat(CMD_SRC_IP, 4'd7, 1'b1, 32'h1234_5678, 6'd0));
		send_beat(header(32'h0A00_0001, 32'h0B00_0001, 16'd7, 16'd9, 8'd6));
		send_beat(net_entry_beat(CMD_SRC_IP, 4'd7, 1'b0, 32'h1234_5678, 6'd0));
		send_beat(header(32'hC0A8_0101, 32'h0B00_0001, PORT_DNS, 16'd9, 8'd6));
	endtask

	// sender holds off twice until nothing is outstanding
	task automatic test_paused_sender();
		for (int round = 0; round < 2; round++) begin
			for (int i = 0; i < 6; i++) send_beat(header_beat());
			hold_until_drained();
		end
	endtask

	// random mix of loads, aimed headers and noise, with burst stretches
	task automatic test_random_traffic();
		int       counted;
		int       pick;
		pbf_req_t b;
		counted = 0;
		while (counted < RANDOM_BEATS) begin
			if ($urandom_range(0, 39) == 0) gap_max = (gap_max != 0) ? 0 : 8;
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				b = random_beat();
			end else if (pick < 30) begin
				b = load_beat();
			end else begin
				b = header_beat();
			end
			if (b.cmd <= CMD_DST_PORT) counted++;
			send_beat(b);
			if ($urandom_range(0, 149) == 0) hold_until_drained();
		end
		gap_max = 8;
	endtask

	// run limit
	initial begin
		#(RUN_LIMIT);
		$display("** packet_header_blocklist_filter: FAILED **");
		$finish;
	end

	// test sequence
	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		gap_max    = 8;
		mismatches = 0;
		src_net_on = '0;
		dst_net_on = '0;
		sport_on   = '0;
		dport_on   = '0;
		for (int i = 0; i < NET_SLOTS; i++) begin
			src_net_base[i] = '0;
			src_net_keep[i] = '0;
			dst_net_base[i] = '0;
			dst_net_keep[i] = '0;
		end
		for (int i = 0; i < PORT_SLOTS; i++) begin
			sport_blk[i] = '0;
			dport_blk[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tables();
		test_early_accepts();
		test_table_loads();
		test_paused_sender();
		test_random_traffic();

		hold_until_drained();
		repeat (SCAN_SETTLE) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			report_mismatch("verdicts never delivered", pending_verdicts.size(), 32'd0);
		end
		if (mismatches == 0) begin
			$display("** packet_header_blocklist_filter: PASSED **");
		end else begin
			$display("** packet_header_blocklist_filter: FAILED **");
		end
		$finish;
	end

endmodule
